[src/mivg_pkg.sv]
// ----------------------------------------------------------------------------
// mivg_pkg: shared types and constants for the inverted-v gesture detector
// phase codes, config register indexes, stroke sum width, state, packet and config structs
// ----------------------------------------------------------------------------
package mivg_pkg;

	localparam int SUM_WIDTH  = 20;
	localparam int MOVE_WIDTH = 9;
	localparam int CFG_WIDTH  = 8;
	localparam int PHASE_WIDTH = 3;

	// configuration register indexes
	localparam logic REG_MIN_X_LENGTH   = 1'b0;
	localparam logic REG_MOVE_TOLERANCE = 1'b1;

	typedef enum logic [PHASE_WIDTH-1:0] {
		PH_INITIAL  = 3'd0,
		PH_UP       = 3'd1,
		PH_TOP      = 3'd2,
		PH_DOWN     = 3'd3,
		PH_COMPLETE = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t                       phase;
		logic signed [SUM_WIDTH-1:0]  sum_x;
		logic signed [SUM_WIDTH-1:0]  sum_y;
		logic                         right_held;
		logic                         left_held;
	} state_t;

	typedef struct packed {
		logic                          left_button;
		logic                          right_button;
		logic                          middle_button;
		logic                          x_overflow;
		logic                          y_overflow;
		logic signed [MOVE_WIDTH-1:0]  move_x;
		logic signed [MOVE_WIDTH-1:0]  move_y;
	} packet_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] min_x_length;
		logic [CFG_WIDTH-1:0] move_tolerance;
	} cfg_t;

endpackage

[src/mivg_pkt_if.sv]
// ----------------------------------------------------------------------------
// mivg_pkt_if: decoded mouse packet channel
// valid/ready handshake with button, overflow and movement fields
// ----------------------------------------------------------------------------
interface mivg_pkt_if;
	logic              valid;
	logic              ready;
	logic              left_button;
	logic              right_button;
	logic              middle_button;
	logic              x_overflow;
	logic              y_overflow;
	logic signed [8:0] move_x;
	logic signed [8:0] move_y;

	modport source (
		output valid, left_button, right_button, middle_button,
		output x_overflow, y_overflow, move_x, move_y,
		input  ready
	);
	modport sink (
		input  valid, left_button, right_button, middle_button,
		input  x_overflow, y_overflow, move_x, move_y,
		output ready
	);
endinterface

[src/mivg_res_if.sv]
// ----------------------------------------------------------------------------
// mivg_res_if: gesture result channel
// valid/ready handshake with phase and done fields
// ----------------------------------------------------------------------------
interface mivg_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] gesture_phase;
	logic       gesture_done;

	modport source (
		output valid, gesture_phase, gesture_done,
		input  ready
	);
	modport sink (
		input  valid, gesture_phase, gesture_done,
		output ready
	);
endinterface

[src/mivg_step.sv]
// ----------------------------------------------------------------------------
// mivg_step: next-state logic for one packet
// classifies the packet into an event and advances the phase machine
// ----------------------------------------------------------------------------
module mivg_step (
	input  mivg_pkg::state_t  cur,
	input  mivg_pkg::packet_t pkt,
	input  mivg_pkg::cfg_t    cfg,
	output mivg_pkg::state_t  nxt
);

	localparam int SW = mivg_pkg::SUM_WIDTH;
	localparam int MW = mivg_pkg::MOVE_WIDTH;

	logic signed [SW:0]   add_x;
	logic signed [SW:0]   add_y;
	logic signed [SW:0]   diag;
	logic signed [SW-1:0] sat_x;
	logic signed [SW-1:0] sat_y;
	logic signed [SW-1:0] minx_ext;
	logic signed [MW:0]   dx10;
	logic signed [MW:0]   dy10;
	logic signed [MW:0]   tol10;
	logic signed [MW:0]   dx_lo;
	logic signed [MW:0]   dx_hi;
	logic signed [MW:0]   dy_lo;
	logic signed [MW:0]   dy_hi;
	logic                 x_below;
	logic                 x_above;
	logic                 y_below;
	logic                 y_above;
	logic                 rise_ok;
	logic                 fall_ok;

	// saturating stroke sums
	assign add_x = {cur.sum_x[SW-1], cur.sum_x} + {{(SW+1-MW){pkt.move_x[MW-1]}}, pkt.move_x};
	assign add_y = {cur.sum_y[SW-1], cur.sum_y} + {{(SW+1-MW){pkt.move_y[MW-1]}}, pkt.move_y};
	assign sat_x = (add_x[SW] != add_x[SW-1]) ? {add_x[SW], {(SW-1){~add_x[SW]}}}
	                                          : add_x[SW-1:0];
	assign sat_y = (add_y[SW] != add_y[SW-1]) ? {add_y[SW], {(SW-1){~add_y[SW]}}}
	                                          : add_y[SW-1:0];

	// tolerance window, done as sign checks on 10-bit sums
	assign dx10    = {pkt.move_x[MW-1], pkt.move_x};
	assign dy10    = {pkt.move_y[MW-1], pkt.move_y};
	assign tol10   = {2'b00, cfg.move_tolerance};
	assign dx_lo   = dx10 + tol10;
	assign dx_hi   = tol10 - dx10;
	assign dy_lo   = dy10 + tol10;
	assign dy_hi   = tol10 - dy10;
	assign x_below = dx_lo[MW];
	assign x_above = dx_hi[MW];
	assign y_below = dy_lo[MW];
	assign y_above = dy_hi[MW];

	// slope tests without division
	assign minx_ext = {{(SW-mivg_pkg::CFG_WIDTH){1'b0}}, cfg.min_x_length};
	assign diag     = {cur.sum_y[SW-1], cur.sum_y} + {cur.sum_x[SW-1], cur.sum_x};
	assign rise_ok  = (cur.sum_x >= minx_ext) && (cur.sum_y > cur.sum_x);
	assign fall_ok  = (cur.sum_x >= minx_ext) && diag[SW];

	always_comb begin
		nxt = cur;
		if (pkt.middle_button) begin
			nxt.phase = mivg_pkg::PH_INITIAL;
			nxt.sum_x = '0;
			nxt.sum_y = '0;
		end else if (pkt.right_button && !cur.right_held) begin
			nxt.sum_x      = '0;
			nxt.sum_y      = '0;
			nxt.right_held = 1'b1;
			nxt.phase      = (cur.phase == mivg_pkg::PH_TOP) ? mivg_pkg::PH_DOWN
			                                                 : mivg_pkg::PH_INITIAL;
		end else if (!pkt.right_button && cur.right_held) begin
			nxt.right_held = 1'b0;
			if (cur.phase == mivg_pkg::PH_DOWN && fall_ok) begin
				nxt.phase = mivg_pkg::PH_COMPLETE;
			end else begin
				nxt.phase = mivg_pkg::PH_INITIAL;
				nxt.sum_x = '0;
				nxt.sum_y = '0;
			end
		end else if (pkt.left_button && !cur.left_held) begin
			nxt.sum_x     = '0;
			nxt.sum_y     = '0;
			nxt.left_held = 1'b1;
			nxt.phase     = (cur.phase == mivg_pkg::PH_INITIAL ||
			                 cur.phase == mivg_pkg::PH_TOP) ? mivg_pkg::PH_UP
			                                                : mivg_pkg::PH_INITIAL;
		end else if (!pkt.left_button && cur.left_held) begin
			nxt.left_held = 1'b0;
			if (cur.phase == mivg_pkg::PH_UP && rise_ok) begin
				nxt.phase = mivg_pkg::PH_TOP;
			end else begin
				nxt.phase = mivg_pkg::PH_INITIAL;
				nxt.sum_x = '0;
				nxt.sum_y = '0;
			end
		end else if (!pkt.x_overflow && !pkt.y_overflow) begin
			unique case (cur.phase)
				mivg_pkg::PH_TOP: begin
					if (x_below || x_above || y_below || y_above) begin
						nxt.phase = mivg_pkg::PH_INITIAL;
						nxt.sum_x = '0;
						nxt.sum_y = '0;
					end
				end
				mivg_pkg::PH_UP: begin
					if (x_below || y_below) begin
						nxt.phase = mivg_pkg::PH_INITIAL;
						nxt.sum_x = '0;
						nxt.sum_y = '0;
					end else begin
						nxt.sum_x = sat_x;
						nxt.sum_y = sat_y;
					end
				end
				mivg_pkg::PH_DOWN: begin
					if (x_below || y_above) begin
						nxt.phase = mivg_pkg::PH_INITIAL;
						nxt.sum_x = '0;
						nxt.sum_y = '0;
					end else begin
						nxt.sum_x = sat_x;
						nxt.sum_y = sat_y;
					end
				end
				default: begin
					// initial and complete ignore movement
				end
			endcase
		end else begin
			nxt.phase = mivg_pkg::PH_INITIAL;
			nxt.sum_x = '0;
			nxt.sum_y = '0;
		end
	end

endmodule

[src/mouse_inverted_v_gesture_detector_core.sv]
// ----------------------------------------------------------------------------
// mouse_inverted_v_gesture_detector_core: inverted-v mouse gesture detector
// one result item per packet item, giving the phase after that packet
// ----------------------------------------------------------------------------
// path: a packet is held in the input register, then moves into the result
//   register when the result side is free
// throughput: one item per cycle unless the result side stalls; the gesture
//   state updates as an item moves from input register to result register
// reset: arst_n clears phase, stroke sums, held-button flags, both config
//   registers and all valid flags; no clearing pass, ready right after reset
module mouse_inverted_v_gesture_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [mivg_pkg::CFG_WIDTH-1:0]    cfg_data,
	mivg_pkt_if.sink                          pkt,
	mivg_res_if.source                        res
);

	// configuration registers
	mivg_pkg::cfg_t    cfg_q;

	// input register stage
	logic              valid_s1;
	mivg_pkg::packet_t pkt_s1;

	// gesture state
	mivg_pkg::state_t  state_q;
	mivg_pkg::state_t  state_nxt;

	// result register
	logic                                res_valid_q;
	logic [mivg_pkg::PHASE_WIDTH-1:0]    res_phase_q;
	logic                                res_done_q;

	logic              pkt_take;
	logic              advance;

	// s1 moves on whenever the result register is empty or being drained
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || advance;
	assign pkt_take = pkt.valid && pkt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mivg_pkg::REG_MIN_X_LENGTH:   cfg_q.min_x_length   <= cfg_data;
				mivg_pkg::REG_MOVE_TOLERANCE: cfg_q.move_tolerance <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			pkt_s1.left_button   <= pkt.left_button;
			pkt_s1.right_button  <= pkt.right_button;
			pkt_s1.middle_button <= pkt.middle_button;
			pkt_s1.x_overflow    <= pkt.x_overflow;
			pkt_s1.y_overflow    <= pkt.y_overflow;
			pkt_s1.move_x        <= pkt.move_x;
			pkt_s1.move_y        <= pkt.move_y;
		end
	end

	// event decode and phase machine
	mivg_step u_step (
		.cur (state_q),
		.pkt (pkt_s1),
		.cfg (cfg_q),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= mivg_pkg::PH_INITIAL;
			state_q.sum_x      <= '0;
			state_q.sum_y      <= '0;
			state_q.right_held <= 1'b0;
			state_q.left_held  <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register, decoupled from the input side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_phase_q <= state_nxt.phase;
			res_done_q  <= (state_nxt.phase == mivg_pkg::PH_COMPLETE);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.gesture_phase = res_phase_q;
	assign res.gesture_done  = res_done_q;

endmodule

[src/mivg_checker.sv]
// ----------------------------------------------------------------------------
// mivg_checker: port-level assertions for the gesture detector
// checks result hold under stall, result consistency and input readiness
// ----------------------------------------------------------------------------
module mivg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pkt_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_phase,
	input logic       res_done
);

	// stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_phase) && $stable(res_done))
		else $error("result item changed while stalled");

	// done flag matches the complete phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_done == (res_phase == 3'(mivg_pkg::PH_COMPLETE))))
		else $error("gesture_done disagrees with gesture_phase");

	// phase stays within the five defined phases
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_phase <= 3'(mivg_pkg::PH_COMPLETE)))
		else $error("gesture_phase out of range");

	// with the result register empty, nothing may block the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pkt_ready)
		else $error("packet input stalled with empty result register");

endmodule

bind mouse_inverted_v_gesture_detector_core mivg_checker u_mivg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pkt_ready (pkt.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_phase (res.gesture_phase),
	.res_done  (res.gesture_done)
);
